// ===== src/ofd_pkg.sv =====
`timescale 1ns / 1ps

package ofd_pkg;

    // Field widths
    localparam int DATA_W    = 24;
    localparam int FRAC_BITS = 12;
    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 23;
    localparam int SHARE_W   = 17;
    localparam int CFG_W     = 16;

    // CORDIC vectoring
    localparam int CORDIC_ITERS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NUM_ITERS    = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
    localparam int GUARD_BITS   = 8;
    localparam int CORDIC_W     = DATA_W + GUARD_BITS + 4;
    localparam int PHASE_W      = 34;
    localparam int ATAN_W       = 30;
    localparam int ANG_SHIFT    = 15;   // phase 2^31 = 180 deg -> 2^16 = 180 deg
    localparam int ANG_W        = PHASE_W + 1 - ANG_SHIFT;

    localparam logic signed [PHASE_W-1:0] QUARTER_PHASE = PHASE_W'(64'sd1073741824);
    localparam logic signed [PHASE_W:0]   ANG_ROUND     = (PHASE_W+1)'(64'sd16384);

    localparam logic signed [ANG_W-1:0] ANG_ONE    = ANG_W'(65536);
    localparam logic signed [ANG_W-1:0] ANG_HALF   = ANG_W'(32768);
    localparam logic signed [ANG_W-1:0] ANG_THREEH = ANG_W'(98304);

    localparam logic [SHARE_W-1:0] SHARE_HALF = SHARE_W'(32768);
    localparam logic [SHARE_W-1:0] SHARE_ONE  = SHARE_W'(65536);

    // Square root
    localparam int SQ_W       = 2 * DATA_W;
    localparam int REM_W      = DATA_W + 2;
    localparam int SQRT_STEPS = DATA_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // Input op codes
    localparam logic OP_VELOCITY = 1'b0;
    localparam logic OP_OBSTACLE = 1'b1;

    // Configuration register indexes
    localparam logic REG_VELOCITY_GAIN   = 1'b0;
    localparam logic REG_VELOCITY_ENABLE = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
    } ofd_in_t;

    typedef struct packed {
        logic [SHARE_W-1:0] share_left;
        logic [SHARE_W-1:0] share_right;
        logic [DATA_W-1:0]  distance;
        logic [SPEED_W-1:0] speed_level;
    } ofd_out_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] idx;
    } ofd_cordic_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } ofd_sqrt_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ITER,
        ST_FINISH
    } ofd_state_t;

    // atan(2^-i) with 2^31 = 180 degrees
    function automatic logic [ATAN_W-1:0] atan_phase(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] r;
        case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ofd_cordic.sv =====
`timescale 1ns / 1ps

module ofd_cordic (
    input  logic                                     aclk,
    input  ofd_pkg::ofd_cordic_ctrl_t                ctrl,
    input  logic signed [ofd_pkg::DATA_W-1:0]        x_in,
    input  logic signed [ofd_pkg::DATA_W-1:0]        z_in,
    output logic signed [ofd_pkg::PHASE_W-1:0]       phase
);

    localparam int CW = ofd_pkg::CORDIC_W;
    localparam int PW = ofd_pkg::PHASE_W;

    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [PW-1:0] phase_reg;

    logic signed [CW-1:0] x_s, z_s;
    logic signed [CW-1:0] px_load, py_load;
    logic signed [PW-1:0] ph_load;
    logic signed [CW-1:0] dx, dy;
    logic signed [PW-1:0] atan_s;

    assign x_s = {{(CW-ofd_pkg::DATA_W-ofd_pkg::GUARD_BITS){x_in[ofd_pkg::DATA_W-1]}},
                  x_in, {ofd_pkg::GUARD_BITS{1'b0}}};
    assign z_s = {{(CW-ofd_pkg::DATA_W-ofd_pkg::GUARD_BITS){z_in[ofd_pkg::DATA_W-1]}},
                  z_in, {ofd_pkg::GUARD_BITS{1'b0}}};

    // left half plane: pre-rotate by a quarter turn
    always_comb begin
        px_load = x_s;
        py_load = z_s;
        ph_load = '0;
        if (x_s < 0) begin
            if (z_s >= 0) begin
                px_load = z_s;
                py_load = -x_s;
                ph_load = ofd_pkg::QUARTER_PHASE;
            end else begin
                px_load = -z_s;
                py_load = x_s;
                ph_load = -ofd_pkg::QUARTER_PHASE;
            end
        end
    end

    assign dx     = py_reg >>> ctrl.idx;
    assign dy     = px_reg >>> ctrl.idx;
    assign atan_s = PW'(ofd_pkg::atan_phase(ctrl.idx));

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            px_reg    <= px_load;
            py_reg    <= py_load;
            phase_reg <= ph_load;
        end else if (ctrl.step) begin
            if (py_reg >= 0) begin
                px_reg    <= px_reg + dx;
                py_reg    <= py_reg - dy;
                phase_reg <= phase_reg + atan_s;
            end else begin
                px_reg    <= px_reg - dx;
                py_reg    <= py_reg + dy;
                phase_reg <= phase_reg - atan_s;
            end
        end
    end

    assign phase = phase_reg;

endmodule

// ===== src/ofd_sqrt.sv =====
`timescale 1ns / 1ps

module ofd_sqrt (
    input  logic                              aclk,
    input  ofd_pkg::ofd_sqrt_ctrl_t           ctrl,
    input  logic [ofd_pkg::SQ_W-1:0]          radicand,
    output logic [ofd_pkg::DATA_W-1:0]        root
);

    localparam int DW = ofd_pkg::DATA_W;
    localparam int RW = ofd_pkg::REM_W;
    localparam int SW = ofd_pkg::SQ_W;

    logic [SW-1:0] rad_reg;
    logic [DW-1:0] root_reg;
    logic [RW-1:0] rem_reg;

    logic [RW+1:0] rem_t, trial, diff;
    logic          ge;
    logic [DW:0]   rounded;

    // restoring square root, one result bit per step
    assign rem_t = {rem_reg, rad_reg[SW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = (rem_t >= trial);
    assign diff  = rem_t - trial;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (ctrl.step) begin
            rad_reg  <= rad_reg << 2;
            root_reg <= {root_reg[DW-2:0], ge};
            rem_reg  <= ge ? diff[RW-1:0] : rem_t[RW-1:0];
        end
    end

    // round to nearest: bump when remainder exceeds root
    assign rounded = {1'b0, root_reg} + (DW+1)'(rem_reg > RW'(root_reg));
    assign root    = rounded[DW] ? {DW{1'b1}} : rounded[DW-1:0];

endmodule

// ===== src/obstacle_force_distribution.sv =====
`timescale 1ns / 1ps

// Obstacle force distribution.
// Input channel s_*: op 0 carries a velocity (stored, no result); op 1 carries
// an obstacle location (x, z) and produces one result transaction on m_*.
// Result: left/right force shares from atan2(z, x), the rounded distance
// sqrt(x^2 + z^2), and the speed level |velocity| * gain / 4096 (recomputed only
// when velocity_enable is set, held otherwise).
// An obstacle holds s_ready low from acceptance until its result is loaded
// into the output register; a velocity leaves the block idle. The work is
// the shared multiplier pass (x^2, z^2, velocity * gain) and the 24-step
// bit-serial square root, with the CORDIC angle iterations overlapped
// inside the root steps.
// The output register holds one result; if the receiver stalls, the block
// finishes the next obstacle and then waits with s_ready low until the
// register frees.
// Reset: gain 4096, enable 1, stored velocity and speed level 0, no result.
// Configuration writes on cfg_we take effect the next cycle; write while idle.
module obstacle_force_distribution (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ofd_pkg::ofd_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ofd_pkg::ofd_out_t                m_data,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [ofd_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int DW  = ofd_pkg::DATA_W;
    localparam int CNW = ofd_pkg::CNT_W;
    localparam int SW  = ofd_pkg::SQ_W;
    localparam int AW  = ofd_pkg::ANG_W;

    localparam logic [CNW-1:0] SQ_STEP_X     = CNW'(0);
    localparam logic [CNW-1:0] SQ_STEP_Z     = CNW'(1);
    localparam logic [CNW-1:0] SQ_STEP_GAIN  = CNW'(2);
    localparam logic [CNW-1:0] SQ_STEP_SPEED = CNW'(3);
    localparam logic [CNW-1:0] ITER_LAST     = CNW'(ofd_pkg::SQRT_STEPS - 1);
    localparam logic [CNW-1:0] CORDIC_LAST   = CNW'(ofd_pkg::NUM_ITERS - 1);
    localparam logic [SW-1:0]  SPEED_ROUND   = SW'(1) << (ofd_pkg::FRAC_BITS - 1);

    ofd_pkg::ofd_state_t state_reg, state_next;
    logic [CNW-1:0]      cnt_reg, cnt_next;

    logic [ofd_pkg::GAIN_W-1:0]  gain_reg;
    logic                        enable_reg;
    logic signed [DW-1:0]        velocity_reg;
    logic [ofd_pkg::SPEED_W-1:0] speed_reg;

    logic [DW-1:0] ax_reg, az_reg;
    logic          zero_reg;
    logic [SW-1:0] prod_reg, sumsq_reg;

    logic              out_valid_reg;
    ofd_pkg::ofd_out_t out_data_reg;

    logic s_accept, obstacle_accept, out_load;

    ofd_pkg::ofd_cordic_ctrl_t cordic_ctrl;
    ofd_pkg::ofd_sqrt_ctrl_t   sqrt_ctrl;
    logic signed [ofd_pkg::PHASE_W-1:0] phase;
    logic [DW-1:0]                      root;

    logic [DW-1:0] abs_a, abs_b, abs_v;
    logic [DW-1:0] mul_a, mul_b;
    logic [SW-1:0] mul_p, speed_wide;
    logic [SW-ofd_pkg::FRAC_BITS-1:0] speed_shift;

    logic signed [ofd_pkg::PHASE_W:0]   phase_r;
    logic signed [AW-1:0]               ang, ang_c, left_s;
    logic [ofd_pkg::SHARE_W-1:0]        left_share;

    assign s_accept        = s_valid && s_ready;
    assign obstacle_accept = s_accept && (s_data.op == ofd_pkg::OP_OBSTACLE);

    assign abs_a = s_data.value_a[DW-1] ? DW'(-s_data.value_a) : DW'(s_data.value_a);
    assign abs_b = s_data.value_b[DW-1] ? DW'(-s_data.value_b) : DW'(s_data.value_b);
    assign abs_v = velocity_reg[DW-1] ? DW'(-velocity_reg) : DW'(velocity_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ofd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ofd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_data.op == ofd_pkg::OP_OBSTACLE) begin
                    state_next = ofd_pkg::ST_SQUARE;
                    cnt_next   = '0;
                end
            end
            ofd_pkg::ST_SQUARE: begin
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == SQ_STEP_SPEED) begin
                    state_next = ofd_pkg::ST_ITER;
                    cnt_next   = '0;
                end
            end
            ofd_pkg::ST_ITER: begin
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == ITER_LAST) begin
                    state_next = ofd_pkg::ST_FINISH;
                    cnt_next   = '0;
                end
            end
            ofd_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ofd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ofd_pkg::ST_IDLE;
            end
        endcase
    end

    assign cordic_ctrl.load = obstacle_accept;
    assign cordic_ctrl.step = (state_reg == ofd_pkg::ST_ITER) && (cnt_reg <= CORDIC_LAST);
    assign cordic_ctrl.idx  = cnt_reg;
    assign sqrt_ctrl.load   = (state_reg == ofd_pkg::ST_SQUARE) && (cnt_reg == SQ_STEP_SPEED);
    assign sqrt_ctrl.step   = (state_reg == ofd_pkg::ST_ITER);

    ofd_cordic u_cordic (
        .aclk  (aclk),
        .ctrl  (cordic_ctrl),
        .x_in  (s_data.value_a),
        .z_in  (s_data.value_b),
        .phase (phase)
    );

    ofd_sqrt u_sqrt (
        .aclk     (aclk),
        .ctrl     (sqrt_ctrl),
        .radicand (sumsq_reg),
        .root     (root)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= ofd_pkg::GAIN_W'(4096);
            enable_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                ofd_pkg::REG_VELOCITY_GAIN:   gain_reg   <= cfg_wdata;
                ofd_pkg::REG_VELOCITY_ENABLE: enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // shared multiplier: x^2, z^2, then |velocity| * gain
    always_comb begin
        case (cnt_reg)
            SQ_STEP_X: begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            SQ_STEP_Z: begin
                mul_a = az_reg;
                mul_b = az_reg;
            end
            default: begin
                mul_a = abs_v;
                mul_b = DW'(gain_reg);
            end
        endcase
    end

    assign mul_p       = mul_a * mul_b;
    assign speed_wide  = prod_reg + SPEED_ROUND;
    assign speed_shift = speed_wide[SW-1:ofd_pkg::FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (obstacle_accept) begin
            ax_reg   <= abs_a;
            az_reg   <= abs_b;
            zero_reg <= (s_data.value_a == '0) && (s_data.value_b == '0);
        end
        if (state_reg == ofd_pkg::ST_SQUARE) begin
            prod_reg <= mul_p;
            if (cnt_reg == SQ_STEP_Z) begin
                sumsq_reg <= prod_reg;
            end else if (cnt_reg == SQ_STEP_GAIN) begin
                sumsq_reg <= sumsq_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            velocity_reg <= '0;
            speed_reg    <= '0;
        end else begin
            if (s_accept && s_data.op == ofd_pkg::OP_VELOCITY) begin
                velocity_reg <= s_data.value_a;
            end
            if (state_reg == ofd_pkg::ST_SQUARE && cnt_reg == SQ_STEP_SPEED && enable_reg) begin
                speed_reg <= (speed_shift > (SW-ofd_pkg::FRAC_BITS)'(ofd_pkg::SPEED_MAX))
                           ? ofd_pkg::SPEED_MAX
                           : speed_shift[ofd_pkg::SPEED_W-1:0];
            end
        end
    end

    // phase -> angle (65536 = 180 deg), rounded half up, then piecewise share
    assign phase_r = {phase[ofd_pkg::PHASE_W-1], phase} + ofd_pkg::ANG_ROUND;
    assign ang     = phase_r[ofd_pkg::PHASE_W:ofd_pkg::ANG_SHIFT];

    always_comb begin
        if (ang > ofd_pkg::ANG_ONE) begin
            ang_c = ofd_pkg::ANG_ONE;
        end else if (ang < -ofd_pkg::ANG_ONE) begin
            ang_c = -ofd_pkg::ANG_ONE;
        end else begin
            ang_c = ang;
        end
        if (ang_c >= ofd_pkg::ANG_HALF) begin
            left_s = ang_c - ofd_pkg::ANG_HALF;
        end else if (ang_c >= -ofd_pkg::ANG_HALF) begin
            left_s = ofd_pkg::ANG_HALF - ang_c;
        end else begin
            left_s = ofd_pkg::ANG_THREEH + ang_c;
        end
        if (left_s < 0) begin
            left_share = '0;
        end else if (left_s > ofd_pkg::ANG_ONE) begin
            left_share = ofd_pkg::SHARE_ONE;
        end else begin
            left_share = left_s[ofd_pkg::SHARE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg.share_left  <= zero_reg ? ofd_pkg::SHARE_HALF : left_share;
            out_data_reg.share_right <= ofd_pkg::SHARE_ONE
                                      - (zero_reg ? ofd_pkg::SHARE_HALF : left_share);
            out_data_reg.distance    <= root;
            out_data_reg.speed_level <= speed_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // an obstacle transaction blocks the input for its whole computation
    assert property (@(posedge aclk) disable iff (!aresetn)
        obstacle_accept |=> !s_ready)
        else $error("input accepted while obstacle in progress");

    // a velocity transaction never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.op == ofd_pkg::OP_VELOCITY && !m_valid) |=> !m_valid)
        else $error("result produced by velocity transaction");

    // shares always sum to one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (({1'b0, m_data.share_left} + {1'b0, m_data.share_right})
                     == (ofd_pkg::SHARE_W+1)'(65536)))
        else $error("left and right shares do not sum to one");

    // the result register is only loaded from the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ofd_pkg::ST_FINISH))
        else $error("result loaded outside final state");

endmodule

// ===== sim/tb_obstacle_force_distribution.sv =====
`timescale 1ns / 1ps

module tb_obstacle_force_distribution;

    localparam int     DATA_W        = ofd_pkg::DATA_W;
    localparam int     FRAC_BITS     = ofd_pkg::FRAC_BITS;
    localparam int     SHARE_W       = ofd_pkg::SHARE_W;
    localparam int     SPEED_W       = ofd_pkg::SPEED_W;
    localparam int     CFG_W         = ofd_pkg::CFG_W;
    localparam int     NUM_ITERS     = ofd_pkg::NUM_ITERS;

    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     MAX_PRINTED   = 40;
    localparam longint TURN_QUARTER  = 64'sd1073741824;
    localparam longint MID_SHARE     = 32768;
    localparam longint UNIT_SHARE    = 65536;
    localparam longint SPEED_CEIL    = 8388607;
    localparam longint DIST_CEIL     = 16777215;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] z;
        ofd_pkg::ofd_out_t        result;
    } force_expect_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    ofd_pkg::ofd_in_t     s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    ofd_pkg::ofd_out_t    m_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = ofd_pkg::REG_VELOCITY_GAIN;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // predictor state
    longint      model_gain        = 4096;
    logic        model_enable      = 1'b1;
    longint      model_velocity    = 0;
    longint      model_speed_level = 0;
    force_expect_t pending_force_results[$];

    // atan(2^-i), 2^31 = 180 degrees
    longint atan_step [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    obstacle_force_distribution DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint calc_left_share(input longint x, input longint z);
        longint px, py, t, dx, dy, phase, ang, left;
        px    = x * 256;
        py    = z * 256;
        phase = 0;
        // left half plane: rotate by a quarter turn first
        if (px < 0) begin
            if (py >= 0) begin
                t = py; py = -px; px = t; phase = TURN_QUARTER;
            end else begin
                t = -py; py = px; px = t; phase = -TURN_QUARTER;
            end
        end
        for (int i = 0; i < NUM_ITERS; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py >= 0) begin
                px += dx; py -= dy; phase += atan_step[i];
            end else begin
                px -= dx; py += dy; phase -= atan_step[i];
            end
        end
        ang = ((phase + (64'sd1 <<< 40) + 16384) >>> 15) - (64'sd1 <<< 25);
        if (ang > UNIT_SHARE) ang = UNIT_SHARE;
        if (ang < -UNIT_SHARE) ang = -UNIT_SHARE;
        if (ang >= MID_SHARE) left = ang - MID_SHARE;
        else if (ang >= -MID_SHARE) left = MID_SHARE - ang;
        else left = 3 * MID_SHARE + ang;
        if (left < 0) left = 0;
        if (left > UNIT_SHARE) left = UNIT_SHARE;
        return left;
    endfunction

    function automatic longint calc_distance(input longint x, input longint z);
        longint sq, lo, hi, mid;
        sq = x * x + z * z;
        lo = 0;
        hi = 64'sd1 <<< 32;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (mid * mid <= sq) lo = mid;
            else hi = mid;
        end
        if (sq - lo * lo > lo) lo++;
        return (lo > DIST_CEIL) ? DIST_CEIL : lo;
    endfunction

    function automatic force_expect_t predict_force_result(input logic signed [DATA_W-1:0] x,
                                                           input logic signed [DATA_W-1:0] z);
        force_expect_t r;
        longint left, dist_val, av, p;
        if (x == 0 && z == 0) begin
            left     = MID_SHARE;
            dist_val = 0;
        end else begin
            left     = calc_left_share(x, z);
            dist_val = calc_distance(x, z);
        end
        if (model_enable) begin
            av = (model_velocity < 0) ? -model_velocity : model_velocity;
            p  = (av * model_gain + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            model_speed_level = (p > SPEED_CEIL) ? SPEED_CEIL : p;
        end
        r.x                  = x;
        r.z                  = z;
        r.result.share_left  = SHARE_W'(left);
        r.result.share_right = SHARE_W'(UNIT_SHARE - left);
        r.result.distance    = DATA_W'(dist_val);
        r.result.speed_level = SPEED_W'(model_speed_level);
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input force_expect_t item);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d for obstacle (%0d, %0d)",
                                   name, got, want, item.x, item.z));
    endtask

    always @(posedge aclk) begin : force_scoreboard
        force_expect_t     want;
        ofd_pkg::ofd_out_t got;
        ofd_pkg::ofd_in_t  stim;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_force_results.size() == 0) begin
                    report_error($sformatf("result transaction with nothing pending: %h", got));
                end else begin
                    want = pending_force_results.pop_front();
                    check_field("share_left", got.share_left, want.result.share_left, want);
                    check_field("share_right", got.share_right, want.result.share_right, want);
                    check_field("distance", got.distance, want.result.distance, want);
                    check_field("speed_level", got.speed_level, want.result.speed_level, want);
                end
            end
            if (s_valid && s_ready) begin
                stim = s_data;
                if (stim.op == ofd_pkg::OP_VELOCITY)
                    model_velocity = stim.value_a;
                else
                    pending_force_results.push_back(
                        predict_force_result(stim.value_a, stim.value_b));
            end
            // register write lands after any transaction on the same edge
            if (cfg_we) begin
                if (cfg_index == ofd_pkg::REG_VELOCITY_GAIN) model_gain = cfg_wdata;
                else model_enable = cfg_wdata[0];
            end
        end
    end

    // called and returns on a rising edge
    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b);
        ofd_pkg::ofd_in_t item;
        item.op      = op;
        item.value_a = a;
        item.value_b = b;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_force_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] random_coord();
        logic signed [DATA_W-1:0] r;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       r = 24'sh7FFFFF;
                    1:       r = 24'sh800000;
                    2:       r = '0;
                    3:       r = 24'sd1;
                    default: r = -24'sd1;
                endcase
            end
            1, 2:    r = DATA_W'($urandom_range(8192)) - 24'sd4096;
            default: r = DATA_W'($urandom);
        endcase
        return r;
    endfunction

    // defaults after reset: gain 4096, enable on, velocity zero
    task automatic test_reset_defaults();
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd4096, 24'sd4096);
        send_item(ofd_pkg::OP_VELOCITY, 24'sh800000, random_coord());
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd0, 24'sd0);    // zero vector, speed saturates
    endtask

    task automatic test_obstacle_geometry();
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh7FFFFF, 24'sd0);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh800000, 24'sd0);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd0, 24'sh7FFFFF);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd0, 24'sh800000);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh800000, 24'sh800000);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh800000, 24'sh7FFFFF);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sh7FFFFF, 24'sh800000);
        send_item(ofd_pkg::OP_OBSTACLE, -24'sd1, 24'sd0);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd0, -24'sd1);
        send_item(ofd_pkg::OP_OBSTACLE, -24'sd1, -24'sd1);
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd1, 24'sd1);
        send_item(ofd_pkg::OP_OBSTACLE, -24'sd4096, 24'sd1);
    endtask

    task automatic test_velocity_config();
        wait_results_drained();
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, 16'h0000);
        send_item(ofd_pkg::OP_VELOCITY, 24'sh7FFFFF, random_coord());
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd300, -24'sd200);
        wait_results_drained();
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, 16'hFFFF);
        send_item(ofd_pkg::OP_OBSTACLE, -24'sd300, 24'sd200);
        wait_results_drained();
        // only bit 0 of the enable register is kept
        write_reg(ofd_pkg::REG_VELOCITY_ENABLE, 16'hFFFE);
        send_item(ofd_pkg::OP_VELOCITY, 24'sd100, random_coord());
        send_item(ofd_pkg::OP_OBSTACLE, 24'sd5, 24'sd7);
        wait_results_drained();
        write_reg(ofd_pkg::REG_VELOCITY_ENABLE, 16'hFFFF);
        send_item(ofd_pkg::OP_OBSTACLE, -24'sd5, -24'sd7);
    endtask

    task automatic test_random_traffic(input int count);
        logic signed [DATA_W-1:0] a, b;
        for (int n = 0; n < count; n++) begin
            a = random_coord();
            b = random_coord();
            if ($urandom_range(4) == 0) send_item(ofd_pkg::OP_VELOCITY, a, b);
            else send_item(ofd_pkg::OP_OBSTACLE, a, b);
        end
    endtask

    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 46;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_obstacle_geometry();
        test_velocity_config();

        wait_results_drained();
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, CFG_W'($urandom));
        write_reg(ofd_pkg::REG_VELOCITY_ENABLE, 16'h0001);
        test_random_traffic(430);

        wait_results_drained();
        send_idle_pct = 46;
        recv_idle_pct = 13;
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, 16'hFFFF);
        test_random_traffic(215);
        wait_results_drained();
        write_reg(ofd_pkg::REG_VELOCITY_ENABLE, 16'h0000);
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, 16'h0000);
        test_random_traffic(215);

        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ofd_pkg::REG_VELOCITY_GAIN, CFG_W'($urandom));
        write_reg(ofd_pkg::REG_VELOCITY_ENABLE, 16'h0001);
        test_random_traffic(430);

        wait_results_drained();
        if (pending_force_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_force_results.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
